FILE: sv/sor_pkg.sv
package sor_pkg;

    // width of the count field on the result port
    localparam int COUNT_W = 7;

    // control flags that travel with a request along the cell row
    typedef struct packed {
        logic valid;   // a request occupies this slot
        logic clear;   // request began a new array and wipes cells as it passes
        logic placed;  // request value already written into some cell
    } flags_t;

endpackage

FILE: sv/sor_cell.sv
module sor_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_BITS   = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  sor_pkg::flags_t              in_flags,
    input  logic signed [VALUE_BITS-1:0] in_value,
    input  logic [CNT_BITS-1:0]          in_count,
    output sor_pkg::flags_t              out_flags,
    output logic signed [VALUE_BITS-1:0] out_value,
    output logic [CNT_BITS-1:0]          out_count,
    output logic                         occupied
);
    import sor_pkg::*;

    logic signed [VALUE_BITS-1:0] stored_reg;
    logic signed [VALUE_BITS-1:0] stored_next;
    logic                         valid_reg;
    logic                         valid_next;
    flags_t                       flags_reg;
    flags_t                       flags_next;
    logic signed [VALUE_BITS-1:0] value_reg;
    logic [CNT_BITS-1:0]          count_reg;
    logic [CNT_BITS-1:0]          count_next;
    logic                         eff_valid;
    logic                         less;
    logic                         store_here;

    // compare against the held value, or claim the cell if it is free
    always_comb
    begin
        eff_valid   = valid_reg && !in_flags.clear;
        less        = eff_valid && (stored_reg < in_value);
        store_here  = in_flags.valid && !in_flags.placed && !eff_valid;
        stored_next = store_here ? in_value : stored_reg;
        valid_next  = in_flags.valid ? (store_here || eff_valid) : valid_reg;
        count_next  = in_count + CNT_BITS'(less);
        flags_next        = in_flags;
        flags_next.placed = in_flags.placed || store_here;
    end

    // cell contents, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            flags_reg <= flags_next;
        end
    end

    // cell contents, data part
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stored_reg <= stored_next;
            value_reg  <= in_value;
            count_reg  <= count_next;
        end
    end

    assign out_flags = flags_reg;
    assign out_value = value_reg;
    assign out_count = count_reg;
    assign occupied  = valid_reg;

`ifndef ASSERT_OFF
    // a request handed in is present at the output in the following cycle
    a_moves: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_flags.valid |=> out_flags.valid)
        else $error("request lost in cell");

    // a frozen row keeps both the slot and the cell contents
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(out_flags) && $stable(valid_reg))
        else $error("cell changed while row frozen");

    // a start request that stored upstream leaves this cell empty
    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_flags.valid && in_flags.clear && in_flags.placed |=> !occupied)
        else $error("cell not cleared by start request");

    // an unplaced request claims a free or cleared cell
    a_claim: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_flags.valid && !in_flags.placed && (!occupied || in_flags.clear)
        |=> occupied && out_flags.placed)
        else $error("free cell not claimed");

    // each cell adds at most one to the running count
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_flags.valid
        |=> (out_count == $past(in_count)) || (out_count == $past(in_count) + 1'b1))
        else $error("count stepped by more than one");
`endif

endmodule

FILE: sv/smaller_on_right_counter.sv
// Counts, for each array element fed from last to first, how many values
// taken since the last start_req are strictly smaller (signed compare). The
// store is a row of CAPACITY cells, each holding one value; a request walks
// the row one cell per cycle while the row is not frozen, picking up a
// compare result in every filled cell and writing itself into the first free
// one. One request enters per cycle unless req_stall is high. Its result is
// registered in each cell in turn and comes out of the last cell. start_req
// wipes each cell as that request passes it, so requests ahead are
// unaffected. A request that finds no free cell comes out with overflow set.
// A stall on the result side freezes the whole row, and the request side is
// stalled for as long.
module smaller_on_right_counter #(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic signed [VALUE_BITS-1:0]         value,
    input  logic                                 start_req,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output logic [sor_pkg::COUNT_W-1:0]          smaller_count,
    output logic                                 overflow
);
    import sor_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    flags_t                       flags  [CAPACITY+1];
    logic signed [VALUE_BITS-1:0] values [CAPACITY+1];
    logic [CNT_BITS-1:0]          counts [CAPACITY+1];
    logic [CAPACITY-1:0]          occupied;
    logic                         advance;
    logic [COUNT_W+CNT_BITS-1:0]  count_wide;

    // the row moves unless a finished result is held back
    assign advance   = !(res_valid && res_stall);
    assign req_stall = !advance;

    // head of the row
    always_comb
    begin
        flags[0].valid  = req_valid;
        flags[0].clear  = start_req;
        flags[0].placed = 1'b0;
        values[0]       = value;
        counts[0]       = '0;
    end

    // row of compare and store cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sor_cell #(
            .VALUE_BITS (VALUE_BITS),
            .CNT_BITS   (CNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .in_flags  (flags[i]),
            .in_value  (values[i]),
            .in_count  (counts[i]),
            .out_flags (flags[i+1]),
            .out_value (values[i+1]),
            .out_count (counts[i+1]),
            .occupied  (occupied[i])
        );
    end

    // result from the last cell
    assign count_wide    = {{COUNT_W{1'b0}}, counts[CAPACITY]};
    assign smaller_count = count_wide[COUNT_W-1:0];
    assign overflow      = !flags[CAPACITY].placed;
    assign res_valid     = flags[CAPACITY].valid;

`ifndef ASSERT_OFF
    // a start request always finds cell 0 free
    a_start_stores: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && start_req |=> occupied[0] && flags[1].placed)
        else $error("start request not stored in first cell");

    // a request leaving unplaced found the last cell full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |-> occupied[CAPACITY-1])
        else $error("overflow past a free last cell");

    // count never exceeds the number of cells
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> counts[CAPACITY] <= CNT_BITS'(CAPACITY))
        else $error("count out of range");
`endif

endmodule
